FILE: hdl/ssb_pkg.sv
`default_nettype none

package ssb_pkg;

   localparam int unsigned DIM_W    = 10;
   localparam int unsigned SCALE_W  = 7;
   localparam int unsigned PIX_W    = 8;
   localparam int unsigned COORD_W  = 9;
   localparam int unsigned ACC_W    = 7;
   // edges and write positions are signed; the top edge can reach -1534, which needs 12 bits
   localparam int unsigned EDGE_W   = 12;

   localparam logic [SCALE_W-1:0] FULL_SCALE = 7'd100;
   localparam logic [ACC_W:0]     KEEP_LEVEL = 8'd100;

   // divide by 100: (p * 167773) >> 24 is exact for p < 199728
   localparam int unsigned       PROD_W      = 17;
   localparam int unsigned       RECIP_W     = 18;
   localparam int unsigned       RECIP_SHIFT = 24;
   localparam logic [RECIP_W-1:0] RECIP_100  = 18'd167773;

   typedef enum logic [2:0] {
      REG_SCALE,
      REG_FRAME_W,
      REG_FRAME_H,
      REG_ORIGIN_X,
      REG_ORIGIN_Y,
      REG_DEST_W,
      REG_DEST_H,
      REG_KEY
   } reg_index_type;

   typedef struct packed {
      logic        [SCALE_W-1:0] scale;
      logic        [DIM_W-1:0]   width;
      logic        [DIM_W-1:0]   height;
      logic signed [DIM_W-1:0]   origin_x;
      logic signed [DIM_W-1:0]   origin_y;
   } geom_cfg_type;

   typedef struct packed {
      logic signed [EDGE_W-1:0] left;
      logic signed [EDGE_W-1:0] top;
   } edges_type;

endpackage

`default_nettype wire

FILE: hdl/ssb_edge_calc.sv
`default_nettype none

module ssb_edge_calc (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire ssb_pkg::geom_cfg_type cfg,
   output logic                      busy,
   output ssb_pkg::edges_type        edges
);
   import ssb_pkg::*;

   logic [PROD_W-1:0] col_prod_ff, row_prod_ff;
   logic [DIM_W-1:0]  kept_cols_ff, kept_rows_ff;
   logic [PROD_W+RECIP_W-1:0] col_full, row_full;
   logic              pend0_ff, pend1_ff, pend2_ff;
   edges_type         edges_ff, edges_in;

   assign col_full = {{RECIP_W{1'b0}}, col_prod_ff} * {{PROD_W{1'b0}}, RECIP_100};
   assign row_full = {{RECIP_W{1'b0}}, row_prod_ff} * {{PROD_W{1'b0}}, RECIP_100};

   always_comb begin
      if (cfg.scale == '0) begin
         edges_in.left = EDGE_W'(cfg.origin_x);
         edges_in.top  = EDGE_W'(cfg.origin_y);
      end else begin
         edges_in.left = EDGE_W'(cfg.origin_x)
                       - $signed({{(EDGE_W-DIM_W+1){1'b0}}, kept_cols_ff[DIM_W-1:1]});
         edges_in.top  = EDGE_W'(cfg.origin_y)
                       - $signed({{(EDGE_W-DIM_W){1'b0}}, kept_rows_ff})
                       + EDGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      col_prod_ff  <= PROD_W'(cfg.width) * PROD_W'(cfg.scale);
      row_prod_ff  <= PROD_W'(cfg.height) * PROD_W'(cfg.scale);
      kept_cols_ff <= col_full[RECIP_SHIFT +: DIM_W];
      kept_rows_ff <= row_full[RECIP_SHIFT +: DIM_W];
      if (reset) begin
         pend0_ff <= 1'b1;
         pend1_ff <= 1'b0;
         pend2_ff <= 1'b0;
         edges_ff <= '0;
      end else begin
         pend0_ff <= start;
         pend1_ff <= pend0_ff;
         pend2_ff <= pend1_ff;
         if (pend2_ff) begin
            edges_ff <= edges_in;
         end
      end
   end

   assign busy  = pend0_ff | pend1_ff | pend2_ff;
   assign edges = edges_ff;

endmodule

`default_nettype wire

FILE: hdl/scaled_sprite_colorkey_blit_core.sv
`default_nettype none

// Scaled sprite blitter with a color key. Source pixels enter in raster order, one
// transaction per cycle while req_tready is high, and each one yields zero or one
// destination write (x, y, color) in the next cycle through a registered output
// that stalls only when the sink holds rsp_tready low. Row and column keep decisions
// come from two percent accumulators; the scaled sprite is centered on origin_x with
// its bottom row on origin_y and is clipped to the destination. After reset and after
// every register write the frame restarts and req_tready stays low while the sprite
// placement is recomputed (multiply, divide-by-100 by reciprocal, subtract).
module scaled_sprite_colorkey_blit_core #(
   parameter int MAX_DIM = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] src_pixel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [8:0] write_x, [17:9] write_y,
                                         // [25:18] write_value, [31:26] zero
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_addr,
   input  wire logic [9:0]  csr_wdata
);
   import ssb_pkg::*;

   localparam int DIM_LIMIT = (MAX_DIM > 1023) ? 1023 : MAX_DIM;
   localparam logic [DIM_W-1:0] DIM_MAX_V = DIM_W'(DIM_LIMIT);

   // configuration
   logic        [SCALE_W-1:0] scale_ff;
   logic        [DIM_W-1:0]   frame_w_ff, frame_h_ff, dest_w_ff, dest_h_ff;
   logic signed [DIM_W-1:0]   origin_x_ff, origin_y_ff;
   logic        [PIX_W-1:0]   key_ff;

   // effective values
   logic [SCALE_W-1:0] eff_scale;
   logic [DIM_W-1:0]   eff_w, eff_h, eff_dw, eff_dh;

   // frame state
   logic [DIM_W-1:0] src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [ACC_W-1:0] col_acc_ff, col_acc_in, row_acc_ff, row_acc_in;
   logic [DIM_W-1:0] shown_col_ff, shown_col_in, shown_row_ff, shown_row_in;
   logic             row_shown_ff, row_shown_in;

   // output register
   logic               out_valid_ff;
   logic [COORD_W-1:0] out_x_ff, out_y_ff;
   logic [PIX_W-1:0]   out_pix_ff;

   logic               hit;
   logic signed [EDGE_W-1:0] pos_x, pos_y;

   geom_cfg_type geom_cfg;
   edges_type    edges;
   logic         edge_busy;
   logic         take;

   assign eff_scale = (scale_ff > FULL_SCALE) ? FULL_SCALE : scale_ff;
   assign eff_w  = (frame_w_ff == '0) ? DIM_W'(1)
                 : ((frame_w_ff > DIM_MAX_V) ? DIM_MAX_V : frame_w_ff);
   assign eff_h  = (frame_h_ff == '0) ? DIM_W'(1)
                 : ((frame_h_ff > DIM_MAX_V) ? DIM_MAX_V : frame_h_ff);
   assign eff_dw = (dest_w_ff > DIM_MAX_V) ? DIM_MAX_V : dest_w_ff;
   assign eff_dh = (dest_h_ff > DIM_MAX_V) ? DIM_MAX_V : dest_h_ff;

   assign geom_cfg.scale    = eff_scale;
   assign geom_cfg.width    = eff_w;
   assign geom_cfg.height   = eff_h;
   assign geom_cfg.origin_x = origin_x_ff;
   assign geom_cfg.origin_y = origin_y_ff;

   ssb_edge_calc u_edge_calc (
      .clock (clock),
      .reset (reset),
      .start (csr_we),
      .cfg   (geom_cfg),
      .busy  (edge_busy),
      .edges (edges)
   );

   assign req_tready = !edge_busy && !csr_we && (!out_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;

   always_comb begin
      logic [ACC_W:0]   sum;
      logic [ACC_W-1:0] col_base;
      logic [DIM_W-1:0] shown_base;
      logic             col_kept;
      logic             in_x, in_y;

      row_acc_in   = row_acc_ff;
      row_shown_in = row_shown_ff;
      col_base     = col_acc_ff;
      shown_base   = shown_col_ff;
      // first pixel of a row decides whether the row is shown
      if (src_col_ff == '0) begin
         sum          = {1'b0, row_acc_ff} + {1'b0, eff_scale};
         row_shown_in = (sum >= KEEP_LEVEL);
         row_acc_in   = row_shown_in ? ACC_W'(sum - KEEP_LEVEL) : ACC_W'(sum);
         col_base     = '0;
         shown_base   = '0;
      end

      sum        = {1'b0, col_base} + {1'b0, eff_scale};
      col_kept   = (sum >= KEEP_LEVEL);
      col_acc_in = col_kept ? ACC_W'(sum - KEEP_LEVEL) : ACC_W'(sum);

      pos_x = edges.left + $signed({{(EDGE_W-DIM_W){1'b0}}, shown_base});
      pos_y = edges.top  + $signed({{(EDGE_W-DIM_W){1'b0}}, shown_row_ff});
      in_x  = !pos_x[EDGE_W-1] && ({1'b0, pos_x[EDGE_W-2:0]} < EDGE_W'(eff_dw));
      in_y  = !pos_y[EDGE_W-1] && ({1'b0, pos_y[EDGE_W-2:0]} < EDGE_W'(eff_dh));
      hit   = row_shown_in && col_kept && in_x && in_y && (req_tdata != key_ff);

      shown_col_in = col_kept ? shown_base + DIM_W'(1) : shown_base;

      src_col_in   = src_col_ff + DIM_W'(1);
      src_row_in   = src_row_ff;
      shown_row_in = shown_row_ff;
      if ({1'b0, src_col_ff} + (DIM_W+1)'(1) >= {1'b0, eff_w}) begin
         src_col_in = '0;
         if (row_shown_in) begin
            shown_row_in = shown_row_ff + DIM_W'(1);
         end
         src_row_in = src_row_ff + DIM_W'(1);
         if ({1'b0, src_row_ff} + (DIM_W+1)'(1) >= {1'b0, eff_h}) begin
            src_row_in   = '0;
            row_acc_in   = '0;
            shown_row_in = '0;
         end
      end
   end

   // configuration registers; any write restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= FULL_SCALE;
         frame_w_ff  <= DIM_W'(1);
         frame_h_ff  <= DIM_W'(1);
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         dest_w_ff   <= DIM_W'(512);
         dest_h_ff   <= DIM_W'(512);
         key_ff      <= '0;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_SCALE:    scale_ff    <= csr_wdata[SCALE_W-1:0];
            REG_FRAME_W:  frame_w_ff  <= csr_wdata;
            REG_FRAME_H:  frame_h_ff  <= csr_wdata;
            REG_ORIGIN_X: origin_x_ff <= $signed(csr_wdata);
            REG_ORIGIN_Y: origin_y_ff <= $signed(csr_wdata);
            REG_DEST_W:   dest_w_ff   <= csr_wdata;
            REG_DEST_H:   dest_h_ff   <= csr_wdata;
            REG_KEY:      key_ff      <= csr_wdata[PIX_W-1:0];
            default:      key_ff      <= key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_we) begin
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         col_acc_ff   <= '0;
         row_acc_ff   <= '0;
         shown_col_ff <= '0;
         shown_row_ff <= '0;
         row_shown_ff <= 1'b0;
      end else if (take) begin
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         col_acc_ff   <= col_acc_in;
         row_acc_ff   <= row_acc_in;
         shown_col_ff <= shown_col_in;
         shown_row_ff <= shown_row_in;
         row_shown_ff <= row_shown_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (take) begin
         out_valid_ff <= hit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (take && hit) begin
         out_x_ff   <= pos_x[COORD_W-1:0];
         out_y_ff   <= pos_y[COORD_W-1:0];
         out_pix_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_pix_ff, out_y_ff, out_x_ff};

endmodule

`default_nettype wire
